[rtl/assert_macros.svh]
// Assertion shorthands shared by the accumulator RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never be seen at a clock edge
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/scrd_pkg.sv]
// Shared types and constants for the surface current running DFT block.
// No dependencies; imported by front, back and top level.
package scrd_pkg;

  localparam int NUM_FACES   = 6;
  localparam int NUM_COMPS   = 4;
  localparam int FRAC_SHIFT  = 16;
  localparam int FACE_W      = 3;
  localparam int CELL_W      = 10;
  localparam int FREQ_W      = 3;
  localparam int COMP_W      = 2;
  localparam int IN_FIXED_W  = FACE_W + CELL_W + FREQ_W + COMP_W;
  localparam int QUEUE_DEPTH = 4;

  localparam logic REQ_READ      = 1'b1;
  localparam logic FACE_SIDE_NEG = 1'b0;

  localparam logic [COMP_W-1:0] COMP_M_A = 2'd0;
  localparam logic [COMP_W-1:0] COMP_J_A = 2'd2;
  localparam logic [COMP_W-1:0] COMP_J_B = 2'd3;

  typedef struct packed {
    logic rd_only;
    logic oor;
    logic electric;
    logic neg_re;
    logic neg_im;
  } item_ctl_t;

endpackage

[rtl/scrd_front.sv]
// Front end: takes a request, checks the address range, forms the entry
// address and the signed sample sum as magnitude and sign. Uses scrd_pkg.
module scrd_front #(
  parameter int NUM_FREQ       = 8,
  parameter int CELLS_PER_FACE = 1024,
  parameter int SAMPLE_BITS    = 32,
  parameter int TWIDDLE_BITS   = 18,
  parameter int AW             = 18
) (
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              q_full,
  input  logic                              clearing,
  output logic                              q_push,
  input  logic                              req_type,
  input  logic [scrd_pkg::FACE_W-1:0]       face,
  input  logic [scrd_pkg::CELL_W-1:0]       cell_index,
  input  logic [scrd_pkg::FREQ_W-1:0]       freq_index,
  input  logic [scrd_pkg::COMP_W-1:0]       component,
  input  logic signed [SAMPLE_BITS-1:0]     sample_a,
  input  logic signed [SAMPLE_BITS-1:0]     sample_b,
  input  logic signed [SAMPLE_BITS-1:0]     sample_c,
  input  logic signed [SAMPLE_BITS-1:0]     sample_d,
  input  logic signed [TWIDDLE_BITS-1:0]    twiddle_re,
  input  logic signed [TWIDDLE_BITS-1:0]    twiddle_im,
  output scrd_pkg::item_ctl_t               ctl,
  output logic [AW-1:0]                     addr,
  output logic [SAMPLE_BITS+1:0]            smag,
  output logic [TWIDDLE_BITS-1:0]           twr_mag,
  output logic [TWIDDLE_BITS-1:0]           twi_mag
);
  import scrd_pkg::*;

  localparam int MW = SAMPLE_BITS + 2;

  logic              electric;
  logic              flip;
  logic              in_range;
  logic              s_neg;
  logic signed [MW-1:0] sum_ab;
  logic signed [MW-1:0] sum_cd;
  logic signed [MW-1:0] sum;
  logic [AW-1:0]     row;
  logic [AW-1:0]     full_addr;

  assign in_ready = !clearing && !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    electric = (component == COMP_J_A) || (component == COMP_J_B);
    flip     = (face[0] == FACE_SIDE_NEG) == ((component == COMP_M_A) || (component == COMP_J_B));
    in_range = (face < FACE_W'(NUM_FACES)) &&
               (32'(freq_index) < 32'(NUM_FREQ)) &&
               (32'(cell_index) < 32'(CELLS_PER_FACE));

    sum_ab = {{2{sample_a[SAMPLE_BITS-1]}}, sample_a} + {{2{sample_b[SAMPLE_BITS-1]}}, sample_b};
    sum_cd = {{2{sample_c[SAMPLE_BITS-1]}}, sample_c} + {{2{sample_d[SAMPLE_BITS-1]}}, sample_d};
    sum    = electric ? (sum_ab + sum_cd) : sum_ab;
    smag   = sum[MW-1] ? (~sum + 1'b1) : sum;
    s_neg  = sum[MW-1] ^ flip;

    twr_mag = twiddle_re[TWIDDLE_BITS-1] ? (~twiddle_re + 1'b1) : twiddle_re;
    twi_mag = twiddle_im[TWIDDLE_BITS-1] ? (~twiddle_im + 1'b1) : twiddle_im;

    // face*4 + component, then frequency, then cell
    row       = AW'({face, component}) * AW'(NUM_FREQ) + AW'(freq_index);
    full_addr = row * AW'(CELLS_PER_FACE) + AW'(cell_index);
    addr      = in_range ? full_addr : '0;

    ctl.rd_only  = (req_type == REQ_READ);
    ctl.oor      = !in_range;
    ctl.electric = electric;
    ctl.neg_re   = s_neg ^ twiddle_re[TWIDDLE_BITS-1];
    ctl.neg_im   = s_neg ^ twiddle_im[TWIDDLE_BITS-1];
  end

endmodule

[rtl/scrd_queue.sv]
// Short register queue between front and back end.
// Generic payload; uses assert_macros.svh for its checks.
`include "assert_macros.svh"

module scrd_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DW-1:0]    ent_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= wdata;
    end
  end

  `ASSERT_NEVER(a_q_overflow, clk, rst_n, push && full, "queue written while full")
  `ASSERT_IMPL(a_q_underflow, clk, rst_n, pop, !empty, "queue read while empty")

endmodule

[rtl/scrd_back.sv]
// Back end: multiply, round, read-modify-write of the accumulator memory
// with write forwarding, and the result buffer. Uses scrd_pkg, assert_macros.svh.
`include "assert_macros.svh"

module scrd_back #(
  parameter int DEPTH        = 196608,
  parameter int AW           = 18,
  parameter int SAMPLE_BITS  = 32,
  parameter int TWIDDLE_BITS = 18,
  parameter int ACC_BITS     = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  scrd_pkg::item_ctl_t         q_ctl,
  input  logic [AW-1:0]               q_addr,
  input  logic [SAMPLE_BITS+1:0]      q_smag,
  input  logic [TWIDDLE_BITS-1:0]     q_twr_mag,
  input  logic [TWIDDLE_BITS-1:0]     q_twi_mag,
  output logic                        clearing,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ACC_BITS-1:0]         out_acc_re,
  output logic [ACC_BITS-1:0]         out_acc_im,
  output logic                        out_sat
);
  import scrd_pkg::*;

  localparam int MW = SAMPLE_BITS + 2;
  localparam int PW = MW + TWIDDLE_BITS;
  localparam int QW = (PW + 1 > 64) ? PW + 1 : 64;
  localparam int SW = ((ACC_BITS > 64) ? ACC_BITS : 64) + 1;
  localparam int DW = 2 * ACC_BITS;
  localparam int EW = DW + 1;

  localparam logic [PW:0] HALF_MAG  = (PW + 1)'(1) << FRAC_SHIFT;
  localparam logic [PW:0] HALF_ELEC = (PW + 1)'(1) << (FRAC_SHIFT + 1);
  localparam logic [QW-1:0] MAG_LIMIT = {{(QW - 63){1'b0}}, {63{1'b1}}};
  localparam logic signed [SW-1:0] ACC_MAX =
    {{(SW - ACC_BITS + 1){1'b0}}, {(ACC_BITS - 1){1'b1}}};
  localparam logic signed [SW-1:0] ACC_MIN =
    {{(SW - ACC_BITS + 1){1'b1}}, {(ACC_BITS - 1){1'b0}}};

  // {limited, magnitude}: round half away, limit to 2^63-1
  function automatic logic [63:0] round_limit(input logic [PW-1:0] p, input logic el);
    logic [PW:0]   r;
    logic [PW:0]   q;
    logic [QW-1:0] qx;
    r  = {1'b0, p} + (el ? HALF_ELEC : HALF_MAG);
    q  = el ? (r >> (FRAC_SHIFT + 2)) : (r >> (FRAC_SHIFT + 1));
    qx = QW'(q);
    if (qx > MAG_LIMIT) begin
      round_limit = {1'b1, {63{1'b1}}};
    end else begin
      round_limit = {1'b0, qx[62:0]};
    end
  endfunction

  // {clipped, result}
  function automatic logic [ACC_BITS:0] sat_add(input logic [ACC_BITS-1:0] o,
                                                input logic [63:0] i);
    logic signed [SW-1:0] s;
    s = {{(SW - ACC_BITS){o[ACC_BITS-1]}}, o} + {{(SW - 64){i[63]}}, i};
    if (s > ACC_MAX) begin
      sat_add = {1'b1, ACC_MAX[ACC_BITS-1:0]};
    end else if (s < ACC_MIN) begin
      sat_add = {1'b1, ACC_MIN[ACC_BITS-1:0]};
    end else begin
      sat_add = {1'b0, s[ACC_BITS-1:0]};
    end
  endfunction

  logic [DW-1:0] mem [DEPTH];

  logic                  clr_act_r;
  logic [AW-1:0]         clr_addr_r, clr_addr_nxt;

  logic                  s1_v_r;
  item_ctl_t             s1_ctl_r;
  logic [AW-1:0]         s1_addr_r;
  logic [MW-1:0]         s1_smag_r;
  logic [TWIDDLE_BITS-1:0] s1_twr_r;
  logic [TWIDDLE_BITS-1:0] s1_twi_r;

  logic                  s2_v_r;
  item_ctl_t             s2_ctl_r;
  logic [AW-1:0]         s2_addr_r;
  logic [PW-1:0]         s2_pre_r;
  logic [PW-1:0]         s2_pim_r;
  logic [DW-1:0]         mem_q_r;

  logic                  s3_v_r;
  item_ctl_t             s3_ctl_r;
  logic [AW-1:0]         s3_addr_r;
  logic [63:0]           s3_inc_re_r;
  logic [63:0]           s3_inc_im_r;
  logic                  s3_clip_r;
  logic [DW-1:0]         s3_old_r;

  logic                  wr1_v_r, wr2_v_r;
  logic [AW-1:0]         wr1_addr_r, wr2_addr_r;
  logic [DW-1:0]         wr1_data_r, wr2_data_r;

  logic [1:0]            ocnt_r, ocnt_nxt;
  logic [EW-1:0]         ohead_r, otail_r;

  logic                  adv;
  logic                  opush;
  logic                  opop;
  logic                  s3_wr;
  logic                  mem_we;
  logic [63:0]           rl_re, rl_im;
  logic [63:0]           inc_re, inc_im;
  logic [DW-1:0]         old_fwd;
  logic [ACC_BITS:0]     sr_re, sr_im;
  logic [DW-1:0]         new_data;
  logic [EW-1:0]         res;

  assign clearing = clr_act_r;
  assign adv      = (ocnt_r != 2'd2);
  assign q_pop    = adv && !q_empty && !clr_act_r;
  assign opush    = adv && s3_v_r;
  assign opop     = out_valid && out_ready;

  assign out_valid  = (ocnt_r != 2'd0);
  assign out_acc_re = ohead_r[ACC_BITS-1:0];
  assign out_acc_im = ohead_r[DW-1:ACC_BITS];
  assign out_sat    = ohead_r[DW];

  // rounding and sign, second stage
  always_comb begin
    rl_re  = round_limit(s2_pre_r, s2_ctl_r.electric);
    rl_im  = round_limit(s2_pim_r, s2_ctl_r.electric);
    inc_re = s2_ctl_r.neg_re ? (~{1'b0, rl_re[62:0]} + 64'd1) : {1'b0, rl_re[62:0]};
    inc_im = s2_ctl_r.neg_im ? (~{1'b0, rl_im[62:0]} + 64'd1) : {1'b0, rl_im[62:0]};
  end

  // forwarding covers the two writes that the memory read missed
  always_comb begin
    if (wr1_v_r && (wr1_addr_r == s3_addr_r)) begin
      old_fwd = wr1_data_r;
    end else if (wr2_v_r && (wr2_addr_r == s3_addr_r)) begin
      old_fwd = wr2_data_r;
    end else begin
      old_fwd = s3_old_r;
    end
    sr_re    = sat_add(old_fwd[ACC_BITS-1:0], s3_inc_re_r);
    sr_im    = sat_add(old_fwd[DW-1:ACC_BITS], s3_inc_im_r);
    new_data = {sr_im[ACC_BITS-1:0], sr_re[ACC_BITS-1:0]};
    s3_wr    = s3_v_r && !s3_ctl_r.rd_only && !s3_ctl_r.oor;
    mem_we   = adv && s3_wr;
    if (s3_ctl_r.oor) begin
      res = '0;
    end else if (s3_ctl_r.rd_only) begin
      res = {1'b0, old_fwd};
    end else begin
      res = {s3_clip_r | sr_re[ACC_BITS] | sr_im[ACC_BITS], new_data};
    end
  end

  always_comb begin
    clr_addr_nxt = clr_addr_r + 1'b1;
    ocnt_nxt     = ocnt_r + 2'(opush) - 2'(opop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_act_r  <= 1'b1;
      clr_addr_r <= '0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      s3_v_r     <= 1'b0;
      wr1_v_r    <= 1'b0;
      wr2_v_r    <= 1'b0;
      ocnt_r     <= 2'd0;
    end else begin
      if (clr_act_r) begin
        clr_addr_r <= clr_addr_nxt;
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          clr_act_r <= 1'b0;
        end
      end
      if (adv) begin
        s1_v_r  <= q_pop;
        s2_v_r  <= s1_v_r;
        s3_v_r  <= s2_v_r;
        wr1_v_r <= s3_wr;
        wr2_v_r <= wr1_v_r;
      end
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl_r    <= q_ctl;
      s1_addr_r   <= q_addr;
      s1_smag_r   <= q_smag;
      s1_twr_r    <= q_twr_mag;
      s1_twi_r    <= q_twi_mag;
      s2_ctl_r    <= s1_ctl_r;
      s2_addr_r   <= s1_addr_r;
      s2_pre_r    <= PW'(s1_smag_r) * PW'(s1_twr_r);
      s2_pim_r    <= PW'(s1_smag_r) * PW'(s1_twi_r);
      s3_ctl_r    <= s2_ctl_r;
      s3_addr_r   <= s2_addr_r;
      s3_inc_re_r <= inc_re;
      s3_inc_im_r <= inc_im;
      s3_clip_r   <= rl_re[63] | rl_im[63];
      s3_old_r    <= mem_q_r;
      wr1_addr_r  <= s3_addr_r;
      wr1_data_r  <= new_data;
      wr2_addr_r  <= wr1_addr_r;
      wr2_data_r  <= wr1_data_r;
    end
    if (opush && ((ocnt_r == 2'd0) || ((ocnt_r == 2'd1) && opop))) begin
      ohead_r <= res;
    end else if (opop && (ocnt_r == 2'd2)) begin
      ohead_r <= otail_r;
    end
    if (opush && (ocnt_r == 2'd1) && !opop) begin
      otail_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_act_r) begin
      mem[clr_addr_r] <= '0;
    end else if (mem_we) begin
      mem[s3_addr_r] <= new_data;
    end
    if (adv) begin
      mem_q_r <= mem[s1_addr_r];
    end
  end

  `ASSERT_IMPL(a_clr_quiet, clk, rst_n, clr_act_r, !(s1_v_r || s2_v_r || s3_v_r) && (ocnt_r == 2'd0), "request in flight while memory clears")
  `ASSERT_NEXT(a_out_fill, clk, rst_n, s3_v_r && (ocnt_r != 2'd2), ocnt_r != 2'd0, "finished request not buffered")

endmodule

[rtl/surface_current_running_dft.sv]
// Top level of the surface current running DFT accumulator.
// Depends on scrd_pkg, scrd_front, scrd_queue and scrd_back.

// One request per clock is sustained while the output buffer is not full: the
// back end does one read-modify-write of the complex accumulator memory per
// cycle, and writes still in flight are forwarded to a following request on
// the same entry. out_tvalid rises once a taken request has been written into
// the queue and has passed the three back-end stages s1, s2 and s3 into the
// output buffer. After reset in_tready stays low while the memory zeroes all
// 24*NUM_FREQ*CELLS_PER_FACE entries (196608 with the default sizes), one
// entry per cycle. Out-of-range requests return zeros and leave the memory
// alone; read requests return the entry unchanged.
module surface_current_running_dft #(
  parameter int NUM_FREQ       = 8,
  parameter int CELLS_PER_FACE = 1024,
  parameter int SAMPLE_BITS    = 32,
  parameter int TWIDDLE_BITS   = 18,
  parameter int ACC_BITS       = 48
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // face, cell_index, freq_index, component, sample_a..sample_d, twiddle_re, twiddle_im
  input  logic [((scrd_pkg::IN_FIXED_W + 4 * SAMPLE_BITS + 2 * TWIDDLE_BITS + 7) / 8) * 8 - 1:0]
               in_tdata,
  // req_type
  input  logic in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // acc_re, acc_im
  output logic [((2 * ACC_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  // saturated
  output logic out_tuser
);
  import scrd_pkg::*;

  localparam int DEPTH   = NUM_FACES * NUM_COMPS * NUM_FREQ * CELLS_PER_FACE;
  localparam int AW      = $clog2(DEPTH);
  localparam int MW      = SAMPLE_BITS + 2;
  localparam int TB      = TWIDDLE_BITS;
  localparam int OUT_DW  = ((2 * ACC_BITS + 7) / 8) * 8;

  localparam int OFF_CELL = FACE_W;
  localparam int OFF_FREQ = OFF_CELL + CELL_W;
  localparam int OFF_COMP = OFF_FREQ + FREQ_W;
  localparam int OFF_SA   = OFF_COMP + COMP_W;
  localparam int OFF_SB   = OFF_SA + SAMPLE_BITS;
  localparam int OFF_SC   = OFF_SB + SAMPLE_BITS;
  localparam int OFF_SD   = OFF_SC + SAMPLE_BITS;
  localparam int OFF_TR   = OFF_SD + SAMPLE_BITS;
  localparam int OFF_TI   = OFF_TR + TB;

  localparam int CTL_W = $bits(item_ctl_t);
  localparam int QDW   = CTL_W + AW + MW + 2 * TB;

  item_ctl_t       f_ctl, b_ctl;
  logic [AW-1:0]   f_addr, b_addr;
  logic [MW-1:0]   f_smag, b_smag;
  logic [TB-1:0]   f_twr, f_twi, b_twr, b_twi;
  logic [QDW-1:0]  q_wdata, q_rdata;
  logic            q_push, q_pop, q_full, q_empty;
  logic            clearing;
  logic [ACC_BITS-1:0] acc_re, acc_im;

  scrd_front #(
    .NUM_FREQ       (NUM_FREQ),
    .CELLS_PER_FACE (CELLS_PER_FACE),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .TWIDDLE_BITS   (TWIDDLE_BITS),
    .AW             (AW)
  ) u_front (
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .q_full     (q_full),
    .clearing   (clearing),
    .q_push     (q_push),
    .req_type   (in_tuser),
    .face       (in_tdata[FACE_W-1:0]),
    .cell_index (in_tdata[OFF_CELL +: CELL_W]),
    .freq_index (in_tdata[OFF_FREQ +: FREQ_W]),
    .component  (in_tdata[OFF_COMP +: COMP_W]),
    .sample_a   ($signed(in_tdata[OFF_SA +: SAMPLE_BITS])),
    .sample_b   ($signed(in_tdata[OFF_SB +: SAMPLE_BITS])),
    .sample_c   ($signed(in_tdata[OFF_SC +: SAMPLE_BITS])),
    .sample_d   ($signed(in_tdata[OFF_SD +: SAMPLE_BITS])),
    .twiddle_re ($signed(in_tdata[OFF_TR +: TB])),
    .twiddle_im ($signed(in_tdata[OFF_TI +: TB])),
    .ctl        (f_ctl),
    .addr       (f_addr),
    .smag       (f_smag),
    .twr_mag    (f_twr),
    .twi_mag    (f_twi)
  );

  assign q_wdata = {f_ctl, f_addr, f_smag, f_twr, f_twi};
  assign {b_ctl, b_addr, b_smag, b_twr, b_twi} = q_rdata;

  scrd_queue #(
    .DW    (QDW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  scrd_back #(
    .DEPTH        (DEPTH),
    .AW           (AW),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .TWIDDLE_BITS (TWIDDLE_BITS),
    .ACC_BITS     (ACC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_ctl      (b_ctl),
    .q_addr     (b_addr),
    .q_smag     (b_smag),
    .q_twr_mag  (b_twr),
    .q_twi_mag  (b_twi),
    .clearing   (clearing),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_acc_re (acc_re),
    .out_acc_im (acc_im),
    .out_sat    (out_tuser)
  );

  assign out_tdata = OUT_DW'({acc_im, acc_re});

endmodule
